@@ hw/rtl/csu_pkg.sv @@
// Shared types, character constants and decode functions for the C string unescaper.
package csu_pkg;

  // Character codes the decoder looks for.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // Decoder phase. Codes 6 and 7 are unused and behave like PH_ERR.
  typedef enum logic [2:0] {
    PH_OPEN = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEXH = 3'd3,
    PH_HEXL = 3'd4,
    PH_ERR  = 3'd5
  } phase_e;

  // Kind of a result word.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    phase_e     phase;
    logic [3:0] nibble;
  } csu_state_t;

  // Result of one decoder step.
  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    kind_e      kind;
  } csu_res_t;

  // Hex digit value: bit 4 set means the byte is a valid hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Simple escape letter: bit 8 set means the escape is accepted.
  // The NUL escape and every unknown letter come back as not accepted.
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      CH_N:         r = {1'b1, 8'h0A};
      CH_T:         r = {1'b1, 8'h09};
      CH_R:         r = {1'b1, 8'h0D};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      CH_SQUOTE:    r = {1'b1, CH_SQUOTE};
      CH_QUOTE:     r = {1'b1, CH_QUOTE};
      CH_B:         r = {1'b1, 8'h08};
      CH_F:         r = {1'b1, 8'h0C};
      CH_V:         r = {1'b1, 8'h0B};
      CH_A:         r = {1'b1, 8'h07};
      default:      r = {1'b0, CH_NUL};
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/csu_if.sv @@
// Stream interfaces for raw token bytes and for decoded result words.
interface csu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface csu_out_if;
  logic            valid;
  logic            ready;
  logic [7:0]      out_byte;
  csu_pkg::kind_e  kind;

  modport source (output valid, output out_byte, output kind, input ready);
  modport sink (input valid, input out_byte, input kind, output ready);
endinterface

@@ hw/rtl/c_string_literal_unescaper.sv @@
// Top level of the C string literal unescaper: input stage, decoder state and result stage.
//
//   channel | dir | payload             | word
//   in_i    | in  | in_byte, is_last    | one raw byte of a quoted token
//   out_o   | out | out_byte, kind      | a decoded byte or the token verdict
//
// One byte per cycle while out_o is not stalled: a byte is decoded combinationally
// once it lands in the input stage, and its result word is registered onto out_o.
// The input stage holds one byte while a result word waits on out_o, so a stall on
// the output side does not hold off the input until both stages are full.
// Reset returns the decoder to waiting for an opening quote and empties both stages.
module c_string_literal_unescaper (
  input  logic     clk_i,
  input  logic     rst_ni,
  csu_in_if.sink   in_i,
  csu_out_if.source out_o
);
  import csu_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  csu_state_t state_q;
  csu_state_t state_d;
  csu_res_t   res;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  kind_e      out_kind_q;
  logic       out_free;
  logic       advance;

  csu_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // A held byte retires when it makes no word or the result stage can take its word.
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && (!res.emit || out_free);
  assign in_i.ready = !in_valid_q || advance;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.is_last;
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase  <= PH_OPEN;
      state_q.nibble <= 4'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res.emit) begin
      out_byte_q <= res.out_byte;
      out_kind_q <= res.kind;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.kind     = out_kind_q;

endmodule

@@ hw/rtl/csu_step.sv @@
// Combinational decode of one token byte against the current decoder state.
module csu_step (
  input  csu_pkg::csu_state_t state_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output csu_pkg::csu_state_t state_o,
  output csu_pkg::csu_res_t   res_o
);
  import csu_pkg::*;

  logic [4:0] hex;
  logic [8:0] esc;

  assign hex = hex_nibble(byte_i);
  assign esc = simple_escape(byte_i);

  // Next state.
  always_comb begin
    state_o = state_i;
    if (last_i) begin
      state_o.phase  = PH_OPEN;
      state_o.nibble = 4'd0;
    end else begin
      unique case (state_i.phase)
        PH_OPEN: state_o.phase = (byte_i == CH_QUOTE) ? PH_BODY : PH_ERR;
        PH_BODY: begin
          if (byte_i == CH_BACKSLASH) state_o.phase = PH_ESC;
        end
        PH_ESC: begin
          if (byte_i == CH_X) state_o.phase = PH_HEXH;
          else if (esc[8]) state_o.phase = PH_BODY;
          else state_o.phase = PH_ERR;
        end
        PH_HEXH: begin
          if (hex[4]) begin
            state_o.phase  = PH_HEXL;
            state_o.nibble = hex[3:0];
          end else begin
            state_o.phase = PH_ERR;
          end
        end
        PH_HEXL: begin
          if (hex[4]) begin
            state_o.phase  = PH_BODY;
            state_o.nibble = 4'd0;
          end else begin
            state_o.phase = PH_ERR;
          end
        end
        default: state_o.phase = PH_ERR;
      endcase
    end
  end

  // Result word.
  always_comb begin
    res_o.emit     = 1'b0;
    res_o.out_byte = CH_NUL;
    res_o.kind     = KIND_DATA;
    if (last_i) begin
      // The final byte always closes the token with a verdict.
      res_o.emit = 1'b1;
      res_o.kind = (state_i.phase == PH_BODY && byte_i == CH_QUOTE) ? KIND_OK : KIND_BAD;
    end else begin
      unique case (state_i.phase)
        PH_BODY: begin
          if (byte_i != CH_BACKSLASH) begin
            res_o.emit     = 1'b1;
            res_o.out_byte = byte_i;
          end
        end
        PH_ESC: begin
          if (byte_i != CH_X && esc[8]) begin
            res_o.emit     = 1'b1;
            res_o.out_byte = esc[7:0];
          end
        end
        PH_HEXL: begin
          if (hex[4]) begin
            res_o.emit     = 1'b1;
            res_o.out_byte = {state_i.nibble, hex[3:0]};
          end
        end
        default: res_o.emit = 1'b0;
      endcase
    end
  end

endmodule

@@ verif/tb_c_string_literal_unescaper.sv @@
// Self-checking testbench for the C string literal unescaper with its own decode predictor.
module tb_c_string_literal_unescaper;
  import csu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1150;
  localparam int HOLD_START = 600;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  // Ways a random token can be broken.
  typedef enum int {
    FLAW_NONE,
    FLAW_NO_OPEN,
    FLAW_SHORT,
    FLAW_BAD_ESC,
    FLAW_BAD_HEX,
    FLAW_DANGLING,
    FLAW_NO_CLOSE,
    FLAW_NOISE
  } flaw_e;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } token_byte_t;

  typedef struct packed {
    logic [7:0] value;
    kind_e      kind;
  } decoded_word_t;

  logic clk_i;
  logic rst_ni;
  logic hold_off;
  int   cycle_count;
  int   fail_count;
  int   send_gap;
  int   take_gap;

  token_byte_t   bytes_to_send[$];
  decoded_word_t decoded_due[$];

  // Predictor state for the token being decoded.
  phase_e     tok_phase;
  logic [3:0] tok_nibble;

  csu_in_if  in_ch ();
  csu_out_if out_ch ();

  c_string_literal_unescaper uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Value of a hex digit character, or -1 when the byte is not one.
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return int'(c) - int'("0");
    end
    if (c >= "a" && c <= "f") begin
      return int'(c) - int'("a") + 10;
    end
    if (c >= "A" && c <= "F") begin
      return int'(c) - int'("A") + 10;
    end
    return -1;
  endfunction

  // Byte produced by a one-letter escape, or -1 when the letter is rejected.
  function automatic int escape_value(input logic [7:0] c);
    case (c)
      CH_N:         return 'h0A;
      CH_T:         return 'h09;
      CH_R:         return 'h0D;
      CH_BACKSLASH: return 'h5C;
      CH_SQUOTE:    return 'h27;
      CH_QUOTE:     return 'h22;
      CH_B:         return 'h08;
      CH_F:         return 'h0C;
      CH_V:         return 'h0B;
      CH_A:         return 'h07;
      default:      return -1;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) begin
      return 8'h30 + {4'd0, v};
    end
    return (upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
  endfunction

  function automatic void push_data(input logic [7:0] v);
    decoded_word_t w;
    w.value = v;
    w.kind = KIND_DATA;
    decoded_due.push_back(w);
  endfunction

  // Advances the predicted decoder by one accepted byte.
  function automatic void decode_token_byte(input logic [7:0] b, input logic last);
    int v;
    decoded_word_t w;
    if (last) begin
      w.value = 8'h00;
      w.kind = (tok_phase == PH_BODY && b == CH_QUOTE) ? KIND_OK : KIND_BAD;
      decoded_due.push_back(w);
      tok_phase = PH_OPEN;
      tok_nibble = 4'd0;
      return;
    end
    case (tok_phase)
      PH_OPEN: begin
        tok_phase = (b == CH_QUOTE) ? PH_BODY : PH_ERR;
      end
      PH_BODY: begin
        if (b == CH_BACKSLASH) begin
          tok_phase = PH_ESC;
        end else begin
          push_data(b);
        end
      end
      PH_ESC: begin
        v = escape_value(b);
        if (b == CH_X) begin
          tok_phase = PH_HEXH;
        end else if (v < 0) begin
          tok_phase = PH_ERR;
        end else begin
          tok_phase = PH_BODY;
          push_data(v[7:0]);
        end
      end
      PH_HEXH: begin
        v = nibble_of(b);
        if (v < 0) begin
          tok_phase = PH_ERR;
        end else begin
          tok_nibble = v[3:0];
          tok_phase = PH_HEXL;
        end
      end
      PH_HEXL: begin
        v = nibble_of(b);
        if (v < 0) begin
          tok_phase = PH_ERR;
        end else begin
          tok_phase = PH_BODY;
          push_data({tok_nibble, v[3:0]});
          tok_nibble = 4'd0;
        end
      end
      default: begin
        tok_phase = PH_ERR;
      end
    endcase
  endfunction

  // Idle length for either side; every fourth stretch of the cycle count runs without idling.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_count / 512) % 4 == 1 || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    token_byte_t t;
    t.value = b;
    t.last = last;
    bytes_to_send.push_back(t);
  endfunction

  // Queues the characters of a string as one token; the final character closes it.
  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], i == s.len() - 1);
    end
  endfunction

  function automatic logic [7:0] draw_plain();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_BACKSLASH) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] draw_bad_escape();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      return CH_ZERO;
    end
    c = 8'($urandom_range(0, 255));
    while (escape_value(c) >= 0 || c == CH_X) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] draw_bad_hex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (nibble_of(c) >= 0) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Body of a well-formed token: plain bytes, simple escapes and hex escapes.
  function automatic void queue_body();
    int body_len;
    int pick;
    logic [7:0] v;
    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    for (int i = 0; i < body_len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        queue_byte(draw_plain(), 1'b0);
      end else if (pick < 8) begin
        queue_byte(CH_BACKSLASH, 1'b0);
        case ($urandom_range(0, 9))
          0: queue_byte(CH_N, 1'b0);
          1: queue_byte(CH_T, 1'b0);
          2: queue_byte(CH_R, 1'b0);
          3: queue_byte(CH_BACKSLASH, 1'b0);
          4: queue_byte(CH_SQUOTE, 1'b0);
          5: queue_byte(CH_QUOTE, 1'b0);
          6: queue_byte(CH_B, 1'b0);
          7: queue_byte(CH_F, 1'b0);
          8: queue_byte(CH_V, 1'b0);
          default: queue_byte(CH_A, 1'b0);
        endcase
      end else begin
        v = 8'($urandom_range(0, 255));
        queue_byte(CH_BACKSLASH, 1'b0);
        queue_byte(CH_X, 1'b0);
        queue_byte(hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b0);
        queue_byte(hex_char(v[3:0], 1'($urandom_range(0, 1))), 1'b0);
      end
    end
  endfunction

  // Bytes swallowed after an error, then the final byte.
  function automatic void queue_tail_after_error();
    int n;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    queue_byte(($urandom_range(0, 1) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void queue_random_token();
    flaw_e flaw;
    logic [7:0] c;
    int n;
    flaw = ($urandom_range(0, 99) < 78) ? FLAW_NONE : flaw_e'($urandom_range(1, 7));
    case (flaw)
      FLAW_SHORT: begin
        queue_byte(($urandom_range(0, 1) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255)), 1'b1);
      end
      FLAW_NOISE: begin
        n = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
          queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      FLAW_NO_OPEN: begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE) begin
          c = 8'($urandom_range(0, 255));
        end
        queue_byte(c, 1'b0);
        queue_body();
        queue_byte(CH_QUOTE, 1'b1);
      end
      default: begin
        queue_byte(CH_QUOTE, 1'b0);
        queue_body();
        case (flaw)
          FLAW_BAD_ESC: begin
            queue_byte(CH_BACKSLASH, 1'b0);
            queue_byte(draw_bad_escape(), 1'b0);
            queue_tail_after_error();
          end
          FLAW_BAD_HEX: begin
            queue_byte(CH_BACKSLASH, 1'b0);
            queue_byte(CH_X, 1'b0);
            if ($urandom_range(0, 1) == 0) begin
              queue_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
            end
            queue_byte(draw_bad_hex(), 1'b0);
            queue_tail_after_error();
          end
          FLAW_DANGLING: begin
            // Final byte lands after a backslash or inside an unfinished hex escape.
            n = $urandom_range(0, 2);
            queue_byte(CH_BACKSLASH, 1'b0);
            if (n > 0) begin
              queue_byte(CH_X, 1'b0);
            end
            if (n > 1) begin
              queue_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
            end
            queue_byte(($urandom_range(0, 1) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255)),
                       1'b1);
          end
          FLAW_NO_CLOSE: begin
            queue_byte(draw_plain(), 1'b1);
          end
          default: begin
            queue_byte(CH_QUOTE, 1'b1);
          end
        endcase
      end
    endcase
  endfunction

  function automatic void flag_mismatch(input string why, input decoded_word_t want,
                                        input decoded_word_t got);
    if (fail_count < REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s: expected byte %02h kind %0d, got byte %02h kind %0d",
               cycle_count, why, want.value, want.kind, got.value, got.kind);
    end
    fail_count++;
  endfunction

  // Byte driver: offers queued bytes with random gaps and predicts each accepted one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_token_byte(in_ch.in_byte, in_ch.is_last);
        void'(bytes_to_send.pop_front());
        send_gap = draw_gap();
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= bytes_to_send[0].value;
        in_ch.is_last <= bytes_to_send[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_due.size() == 0) begin
          flag_mismatch("word with nothing expected", '0, {out_ch.out_byte, out_ch.kind});
        end else if (out_ch.out_byte !== decoded_due[0].value ||
                     out_ch.kind !== decoded_due[0].kind) begin
          flag_mismatch("wrong word", decoded_due.pop_front(), {out_ch.out_byte, out_ch.kind});
        end else begin
          void'(decoded_due.pop_front());
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          take_gap = draw_gap();
        end
      end
    end
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("c_string_literal_unescaper verification failed");
      $finish;
    end
  end

  // Long receiver hold-off while bytes keep coming, so both stages fill and input stalls.
  initial begin
    hold_off = 1'b0;
    while (cycle_count < HOLD_START) begin
      @(posedge clk_i);
    end
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cycle_count = 0;
    fail_count = 0;
    send_gap = 0;
    take_gap = 0;
    tok_phase = PH_OPEN;
    tok_nibble = 4'd0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;

    // Directed tokens: one-byte token, empty string, every escape with both hex cases,
    // the NUL escape, a dangling backslash, a missing opening quote, the final byte
    // inside a hex escape, bad hex digits, an unknown escape.
    queue_text("\"");
    queue_text("\"\"");
    queue_text("\"\\n\\t\\r\\\\\\'\\\"\\b\\f\\v\\a\\xfF\\x00\"");
    queue_text("\"\\0\"");
    queue_text("\"\\");
    queue_text("x\"");
    queue_text("\"\\xA\"");
    queue_text("\"\\xg1\"");
    queue_text("\"\\x4G\"");
    queue_text("\"\\q\"");
    // Byte extremes in the body and a quote inside the body; then a token that never closes.
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_QUOTE, 1'b1);
    queue_byte(CH_QUOTE, 1'b0);
    queue_byte(8'hFF, 1'b1);

    while (bytes_to_send.size() < RANDOM_BYTES) begin
      queue_random_token();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_to_send.size() != 0) begin
      @(posedge clk_i);
    end
    while (decoded_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("c_string_literal_unescaper verification clean");
    end else begin
      $display("c_string_literal_unescaper verification failed");
    end
    $finish;
  end

endmodule
